// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a condition holds at every clock edge outside reset.
`define CHECK_ALWAYS(label, clk, rst_n, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/mfksg_pkg.sv =====
package mfksg_pkg;

	typedef enum logic [2:0] {
		CRS_STEP       = 3'd0,
		CRS_RSTEP      = 3'd1,
		CRS_SINGLE     = 3'd2,
		CRS_RSINGLE    = 3'd3,
		CRS_LEVELS     = 3'd4,
		CRS_RLEVELS    = 3'd5,
		CRS_BAD6       = 3'd6,
		CRS_BAD7       = 3'd7
	} course_t;

	localparam logic [2:0] REG_CELL_COUNT = 3'd0;
	localparam logic [2:0] REG_CELLS_PER_LEVEL = 3'd1;
	localparam logic [2:0] REG_FIELD_COUNT = 3'd2;
	localparam logic [2:0] REG_STRIDE = 3'd3;
	localparam logic [2:0] REG_DISTRIBUTION = 3'd4;
	localparam logic [2:0] REG_COURSE = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PLAN,
		ST_WALK,
		ST_EMIT,
		ST_SINGLE
	} state_t;

	// Command broadcast from the controller into the cell row.
	typedef struct packed {
		logic load;     // reload every cell with its initial value
		logic shift;    // rotate the row by one cell
		logic advance;  // advance the cell at the head before rotating
	} cell_cmd_t;

	// Static settings seen by every cell.
	typedef struct packed {
		logic        rev;
		logic        stepping;
		logic [63:0] total;
		logic [31:0] stride;
	} cell_cfg_t;

endpackage

// ===== hw/rtl/multi_field_key_sequence_generator.sv =====
// The first field of a key leaves the output register after the planning state and
// the walk; fields then follow one per cycle while out_stall is low. A key request
// holds the input through a planning state, one pass round the cell row to advance
// the counters and a second pass that sends the fields; output stalls lengthen it.
// Error and done results pass through planning and ST_SINGLE; a restart reloads
// the cells and stays idle; a register write stalls the input until the reload.
// Reset (arst_n, async) sets the registers to reset values and arms the reload.
module multi_field_key_sequence_generator
	import mfksg_pkg::*;
#(
	parameter int MAX_FIELDS = 16,
	parameter int VALUE_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  field_index,
	output logic [47:0] field_value,
	output logic        last_field,
	output logic        done_res,
	output logic        config_error
);

`include "assert_macros.svh"

	// Configuration registers.
	logic [31:0] cell_count_q;
	logic [15:0] cpl_q;
	logic [4:0]  fcount_q;
	logic [31:0] stride_q;
	logic        dist_q;
	course_t     course_q;

	// Sequence state.
	logic [32:0] cell_index_q;
	logic [15:0] level_repeat_q;
	logic [5:0]  active_q;
	logic        exhausted_q;
	logic        load_q;
	logic        load_pend_q;

	// Walk control.
	state_t      state_q, state_d;
	logic [6:0]  pos_q;
	logic [5:0]  adv_n_q;    // fields to advance, counted from the head
	logic [5:0]  adv_k_q;    // single field to advance when adv_one_q
	logic        adv_one_q;
	logic [5:0]  emit_n_q;
	logic        emit_done_q;
	logic        emit_err_q;
	logic [63:0] total_q;

	// Output register.
	logic [3:0]            o_idx_q;
	logic [VALUE_BITS-1:0] o_val_q;
	logic                  o_last_q;
	logic                  o_done_q;
	logic                  o_err_q;
	logic                  o_valid_q;

	cell_cmd_t             cmd;
	cell_cfg_t             ccfg;
	logic [VALUE_BITS-1:0] init_val;
	logic [VALUE_BITS-1:0] head_cnt;
	logic                  rev;
	logic                  bad;
	logic                  in_acc;
	logic                  out_free;
	logic                  emit_now;
	logic [64:0]           init_wide;

	assign in_acc = in_valid && !in_stall;
	assign out_free = !o_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || load_q || load_pend_q;
	assign rev = (course_q == CRS_RSTEP) || (course_q == CRS_RSINGLE) ||
		(course_q == CRS_RLEVELS);
	// During the second pass only the first emit_n_q positions send a field; the
	// rest of the pass merely brings the row back into order.
	assign emit_now = {1'b0, pos_q[5:0]} < {1'b0, emit_n_q};

	always_comb begin
		bad = 1'b0;
		if (course_q == CRS_BAD6 || course_q == CRS_BAD7 || fcount_q == 5'd0 ||
			{27'd0, fcount_q} > MAX_FIELDS || cpl_q == 16'd0) begin
			bad = 1'b1;
		end else if (cpl_q > 16'd1 && course_q != CRS_STEP && course_q != CRS_RSTEP) begin
			bad = 1'b1;
		end else if (!dist_q) begin
			bad = stride_q > 32'd1;
		end else if (course_q == CRS_LEVELS || course_q == CRS_RLEVELS) begin
			bad = 1'b1;
		end else if (cpl_q > 16'd1 && stride_q > 32'd1) begin
			bad = 1'b1;
		end
	end

	assign init_wide = {1'b0, total_q} + 65'd1;
	assign init_val = rev ? init_wide[VALUE_BITS-1:0] : '0;
	assign ccfg = '{rev: rev, stepping: dist_q, total: total_q, stride: stride_q};

	mfksg_row #(.MAX_FIELDS(MAX_FIELDS), .VALUE_BITS(VALUE_BITS)) u_row (
		.clk     (clk),
		.cmd     (cmd),
		.cfg     (ccfg),
		.init_val(init_val),
		.head_cnt(head_cnt)
	);

	// Configuration, product of the cell count and repeats (one multiply,
	// registered), and the reload after a write. The reload waits in load_pend_q so
	// that the product of the new settings is ready for the initial values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= 32'd1000;
			cpl_q <= 16'd1;
			fcount_q <= 5'd10;
			stride_q <= 32'd1;
			dist_q <= 1'b0;
			course_q <= CRS_STEP;
			load_q <= 1'b1;
			load_pend_q <= 1'b0;
			total_q <= 64'd1000;
		end else begin
			total_q <= {32'd0, cell_count_q} * {48'd0, cpl_q};
			load_q <= load_pend_q;
			load_pend_q <= 1'b0;
			if (cfg_we && cfg_index <= REG_COURSE) begin
				load_pend_q <= 1'b1;
				unique case (cfg_index)
					REG_CELL_COUNT:      cell_count_q <= cfg_wdata;
					REG_CELLS_PER_LEVEL: cpl_q <= cfg_wdata[15:0];
					REG_FIELD_COUNT:     fcount_q <= cfg_wdata[4:0];
					REG_STRIDE:          stride_q <= cfg_wdata;
					REG_DISTRIBUTION:    dist_q <= cfg_wdata[0];
					REG_COURSE:          course_q <= course_t'(cfg_wdata[2:0]);
					default:             load_pend_q <= 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The walk rotates the row once: at each position the head cell advances
	// if the plan says so; during a second full pass the head is emitted at the first emit_n_q positions.
	always_comb begin
		state_d = state_q;
		cmd = '{load: 1'b0, shift: 1'b0, advance: 1'b0};
		if (load_q || (state_q == ST_IDLE && in_acc && restart)) begin
			cmd.load = 1'b1;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (restart) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_PLAN;
					end
				end
			end
			ST_MUL: state_d = ST_PLAN;
			ST_PLAN: begin
				if (emit_err_q || emit_done_q) begin
					state_d = ST_SINGLE;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.shift = 1'b1;
				cmd.advance = adv_one_q ? (pos_q[5:0] == adv_k_q) :
					({1'b0, pos_q[5:0]} < {1'b0, adv_n_q});
				if (pos_q == 7'(MAX_FIELDS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free || !emit_now) begin
					cmd.shift = 1'b1;
					if (pos_q == 7'(MAX_FIELDS - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_SINGLE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequence bookkeeping; performed once for each accepted request other than a restart.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [32:0] ci;
		logic [15:0] lr;
		logic [5:0]  af;
		logic        ok;
		logic [5:0]  nf;
		if (!arst_n) begin
			cell_index_q <= '0;
			level_repeat_q <= '0;
			active_q <= '0;
			exhausted_q <= 1'b0;
			pos_q <= '0;
			adv_n_q <= '0;
			adv_k_q <= '0;
			adv_one_q <= 1'b0;
			emit_n_q <= '0;
			emit_done_q <= 1'b0;
			emit_err_q <= 1'b0;
		end else begin
			if (load_q || (state_q == ST_IDLE && in_acc && restart)) begin
				cell_index_q <= '0;
				level_repeat_q <= '0;
				active_q <= '0;
				exhausted_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_acc && !restart) begin
				ci = cell_index_q;
				lr = level_repeat_q;
				af = active_q;
				nf = {1'b0, fcount_q};
				ok = 1'b1;
				adv_n_q <= '0;
				adv_one_q <= 1'b0;
				adv_k_q <= '0;
				emit_err_q <= bad;
				emit_done_q <= 1'b0;
				pos_q <= '0;
				if (!bad && !exhausted_q) begin
					unique case (course_q)
						CRS_SINGLE, CRS_RSINGLE: begin
							ci = ci + 33'd1;
							if (ci > {1'b0, cell_count_q}) begin
								ok = 1'b0;
							end else begin
								adv_n_q <= nf;
								af = nf;
							end
						end
						CRS_LEVELS: begin
							ci = ci + 33'd1;
							if (ci > {1'b0, cell_count_q} || af == 6'd0) begin
								af = af + 6'd1;
								if (af > nf) begin
									ok = 1'b0;
								end
								ci = 33'd1;
							end
							if (ok) begin
								adv_n_q <= af;
							end
						end
						CRS_RLEVELS: begin
							if (af == 6'd0) begin
								af = nf;
							end
							ci = ci + 33'd1;
							if (ci > {1'b0, cell_count_q}) begin
								af = af - 6'd1;
								if (af == 6'd0) begin
									ok = 1'b0;
								end
								ci = 33'd1;
							end
							if (ok) begin
								adv_n_q <= nf;
							end
						end
						CRS_STEP: begin
							if (af != 6'd0) begin
								lr = lr + 16'd1;
							end
							if (af == 6'd0 || lr == cpl_q) begin
								if (af == 6'd0 || af + 6'd1 > nf) begin
									ci = ci + 33'd1;
									af = 6'd1;
								end else begin
									af = af + 6'd1;
								end
								lr = '0;
							end
							adv_one_q <= 1'b1;
							adv_k_q <= af - 6'd1;
							ok = ci <= {1'b0, cell_count_q};
						end
						default: begin
							if (af != 6'd0) begin
								lr = lr + 16'd1;
							end
							if (af == 6'd0 || lr == cpl_q) begin
								if (af == 6'd0 || af - 6'd1 == 6'd0) begin
									ci = ci + 33'd1;
									af = nf;
									adv_n_q <= nf;
								end else begin
									af = af - 6'd1;
								end
								lr = '0;
							end else begin
								adv_one_q <= 1'b1;
								adv_k_q <= af - 6'd1;
							end
							ok = ci <= {1'b0, cell_count_q};
						end
					endcase
					cell_index_q <= ci;
					level_repeat_q <= lr;
					active_q <= af;
					if (!ok) begin
						exhausted_q <= 1'b1;
						emit_done_q <= 1'b1;
					end
					emit_n_q <= (af > 6'(MAX_FIELDS)) ? 6'(MAX_FIELDS) : af;
				end else if (!bad) begin
					emit_done_q <= 1'b1;
				end
			end
			if (state_q == ST_WALK) begin
				pos_q <= (pos_q == 7'(MAX_FIELDS - 1)) ? 7'd0 : pos_q + 7'd1;
			end
			if (state_q == ST_EMIT && (out_free || !emit_now)) begin
				pos_q <= (pos_q == 7'(MAX_FIELDS - 1)) ? 7'd0 : pos_q + 7'd1;
			end
		end
	end

	// Output register: a transaction waits here while the next is prepared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				o_valid_q <= ((state_q == ST_EMIT) && emit_now) || (state_q == ST_SINGLE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_EMIT) begin
				o_idx_q <= pos_q[3:0];
				o_val_q <= head_cnt;
				o_last_q <= ({1'b0, pos_q[5:0]} + 7'd1 >= {1'b0, emit_n_q});
				o_done_q <= 1'b0;
				o_err_q <= 1'b0;
			end else begin
				o_idx_q <= '0;
				o_val_q <= '0;
				o_last_q <= 1'b0;
				o_done_q <= emit_done_q && !emit_err_q;
				o_err_q <= emit_err_q;
			end
		end
	end

	assign out_valid = o_valid_q;
	assign field_index = o_idx_q;
	assign field_value = 48'(o_val_q);
	assign last_field = o_last_q;
	assign done_res = o_done_q;
	assign config_error = o_err_q;

	`CHECK_ALWAYS(a_one_kind, clk, arst_n,
		!out_valid || !(done_res && config_error) && !(last_field && done_res),
		"result carries more than one kind")
	`CHECK_NEXT(a_no_accept_busy, clk, arst_n, state_q == ST_WALK, in_stall,
		"input accepted during a walk")
	`CHECK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(field_value),
		"stalled result changed")

endmodule

// ===== hw/rtl/mfksg_cell.sv =====
module mfksg_cell
	import mfksg_pkg::*;
#(
	parameter int VALUE_BITS = 48
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic                  head,
	input  cell_cfg_t             cfg,
	input  logic [VALUE_BITS-1:0] init_val,
	input  logic [VALUE_BITS-1:0] cnt_in,
	input  logic [VALUE_BITS-1:0] off_in,
	output logic [VALUE_BITS-1:0] cnt_q,
	output logic [VALUE_BITS-1:0] off_q
);

	logic [64:0] v;
	logic [64:0] off;
	logic [64:0] t;
	logic [64:0] s;
	logic [64:0] v_n;
	logic [64:0] off_n;

	always_comb begin
		v = {{(65-VALUE_BITS){1'b0}}, cnt_in};
		off = {{(65-VALUE_BITS){1'b0}}, off_in};
		t = {1'b0, cfg.total};
		s = {33'd0, cfg.stride};
		v_n = v;
		off_n = off;
		if (!cfg.stepping) begin
			if (cfg.rev) begin
				v_n = (v <= 65'd1) ? t : v - 65'd1;
			end else begin
				v_n = (v + 65'd1 > t) ? 65'd1 : v + 65'd1;
			end
		end else if (cfg.rev) begin
			if (v <= s) begin
				if (off >= t) begin
					off_n = 65'd0;
				end
				v_n = t - off_n;
				off_n = off_n + 65'd1;
			end else begin
				v_n = v - s;
			end
		end else begin
			v_n = v + s;
			if (v_n > t) begin
				off_n = off + 65'd1;
				if (off_n > t) begin
					off_n = 65'd1;
				end
				v_n = off_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q <= init_val;
			off_q <= '0;
		end else if (cmd.shift) begin
			if (cmd.advance && head) begin
				cnt_q <= v_n[VALUE_BITS-1:0];
				off_q <= off_n[VALUE_BITS-1:0];
			end else begin
				cnt_q <= cnt_in;
				off_q <= off_in;
			end
		end
	end

endmodule

// ===== hw/rtl/mfksg_row.sv =====
module mfksg_row
	import mfksg_pkg::*;
#(
	parameter int MAX_FIELDS = 16,
	parameter int VALUE_BITS = 48
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  cell_cfg_t             cfg,
	input  logic [VALUE_BITS-1:0] init_val,
	output logic [VALUE_BITS-1:0] head_cnt
);

	// Cell 0 holds the field at the head; each shift rotates the row so the
	// next field arrives at the head, and MAX_FIELDS shifts restore order.
	// The field leaving the head enters the last cell, which advances it on cmd.advance.
	logic [VALUE_BITS-1:0] cnt [MAX_FIELDS];
	logic [VALUE_BITS-1:0] off [MAX_FIELDS];

	for (genvar i = 0; i < MAX_FIELDS; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_FIELDS;
		mfksg_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.head    (NXT == 0 ? 1'b1 : 1'b0),
			.cfg     (cfg),
			.init_val(init_val),
			.cnt_in  (NXT == i ? cnt[i] : cnt[NXT]),
			.off_in  (NXT == i ? off[i] : off[NXT]),
			.cnt_q   (cnt[i]),
			.off_q   (off[i])
		);
	end

	assign head_cnt = cnt[0];

endmodule
